// ----- sv/engine_throttle_gimbal_slew_defines.svh -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: assertion macros
// Shared property wrappers for the port checker, clocked on i_clk, held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ENGINE_THROTTLE_GIMBAL_SLEW_DEFINES_SVH
`define ENGINE_THROTTLE_GIMBAL_SLEW_DEFINES_SVH

// generic clocked property
`define ETGS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property that only matters while a result is on offer
`define ETGS_ASSERT_OUT(lbl, prop, msg) \
    `ETGS_ASSERT_CLK(lbl, o_out_valid |-> (prop), msg)

`endif

// ----- sv/etgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: package
// Payload types, register map, divider sizing and the sequencer microcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etgs_pkg;

    // Q1.16 full throttle and microseconds per second
    localparam logic [16:0] THR_FULL = 17'd65536;
    localparam logic [26:0] US_PER_S = 27'd1000000;

    localparam int APB_ADDR_W = 5;

    // shared serial divider: 40-bit dividend, 27-bit divisor, 2 bits a cycle
    localparam int DIV_NUM_W         = 40;
    localparam int DIV_DEN_W         = 27;
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = DIV_NUM_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               run_request;
        logic [16:0]        throttle_request;
        logic signed [15:0] gimbal_request_first;
        logic signed [15:0] gimbal_request_second;
        logic [19:0]        elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic               engine_on;
        logic [7:0]         ignitions_spent;
        logic [16:0]        throttle_delivered;
        logic signed [15:0] gimbal_angle_first;
        logic signed [15:0] gimbal_angle_second;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_THR_FLOOR   = 3'd0,
        REG_THR_CEIL    = 3'd1,
        REG_SPOOL_UP    = 3'd2,
        REG_SPOOL_DN    = 3'd3,
        REG_IGN_BUDGET  = 3'd4,
        REG_GIM_LIMIT   = 3'd5,
        REG_GIM_RATE    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_IDLE,
        UOP_PREP,
        UOP_DIV_THR,
        UOP_DIV_GIM,
        UOP_DIV_STEP,
        UOP_THR,
        UOP_GIM
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_uop            uop;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_PREP     = 4'd1;
    localparam logic [PC_W-1:0] PC_THR_LOAD = 4'd2;
    localparam logic [PC_W-1:0] PC_THR_DIV  = 4'd3;
    localparam logic [PC_W-1:0] PC_THR_UPD  = 4'd4;
    localparam logic [PC_W-1:0] PC_GIM_LOAD = 4'd5;
    localparam logic [PC_W-1:0] PC_GIM_DIV  = 4'd6;
    localparam logic [PC_W-1:0] PC_GIM_UPD  = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;
    localparam logic [PC_W-1:0] PC_RETURN   = 4'd9;

    // microcode ROM; a taken jump goes to target, otherwise pc + 1
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_IDLE:     w = '{uop: UOP_IDLE,     cond: COND_NO_INPUT, target: PC_IDLE};
            PC_PREP:     w = '{uop: UOP_PREP,     cond: COND_NEXT,     target: PC_IDLE};
            PC_THR_LOAD: w = '{uop: UOP_DIV_THR,  cond: COND_NEXT,     target: PC_IDLE};
            PC_THR_DIV:  w = '{uop: UOP_DIV_STEP, cond: COND_DIV_BUSY, target: PC_THR_DIV};
            PC_THR_UPD:  w = '{uop: UOP_THR,      cond: COND_NEXT,     target: PC_IDLE};
            PC_GIM_LOAD: w = '{uop: UOP_DIV_GIM,  cond: COND_NEXT,     target: PC_IDLE};
            PC_GIM_DIV:  w = '{uop: UOP_DIV_STEP, cond: COND_DIV_BUSY, target: PC_GIM_DIV};
            PC_GIM_UPD:  w = '{uop: UOP_GIM,      cond: COND_NEXT,     target: PC_IDLE};
            PC_EMIT:     w = '{uop: UOP_NOP,      cond: COND_OUT_FULL, target: PC_EMIT};
            PC_RETURN:   w = '{uop: UOP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
            default:     w = '{uop: UOP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/etgs_div.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: serial divider
// Restoring unsigned divider, a fixed number of quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etgs_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  etgs_pkg::t_div_ctl                    i_ctl,
    input  logic [etgs_pkg::DIV_NUM_W-1:0]        i_dividend,
    input  logic [etgs_pkg::DIV_DEN_W-1:0]        i_divisor,
    output logic [etgs_pkg::DIV_NUM_W-1:0]        o_quot,
    output logic                                  o_busy
);

    logic [etgs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [etgs_pkg::DIV_DEN_W-1:0] r_rem;
    logic [etgs_pkg::DIV_DEN_W-1:0] r_den;
    logic [etgs_pkg::DIV_NUM_W-1:0] r_quo;
    logic [etgs_pkg::DIV_DEN_W-1:0] n_rem;
    logic [etgs_pkg::DIV_NUM_W-1:0] n_quo;

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb begin
        logic [etgs_pkg::DIV_DEN_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < etgs_pkg::DIV_BITS_PER_STEP; k++) begin
            trial = {n_rem, n_quo[etgs_pkg::DIV_NUM_W-1]};
            n_quo = {n_quo[etgs_pkg::DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[etgs_pkg::DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= etgs_pkg::DIV_CNT_W'(etgs_pkg::DIV_STEPS - 1);
        end else if (i_ctl.step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_quo <= i_dividend;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quot = r_quo;
    assign o_busy = (r_cnt != '0);

endmodule

// ----- sv/engine_throttle_gimbal_slew.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew
// One tick in, one result out: run state, ignitions spent, slewed throttle
// and slewed, clamped gimbal angles. A tick is accepted only while the
// sequencer sits at its idle step; after acceptance it runs one setup step,
// two passes through the one shared serial divider at 2 quotient bits a
// cycle, and update and emit steps before it is back at idle;
// a result still waiting in the output register holds the sequencer at its
// emit step, but the output register itself lets the next tick in as soon as
// the sequencer is back at idle. Throttle step is dt*65536/spool time, the
// gimbal step bound is rate*dt/1000000, both floored. Registers sit on an
// APB-style port at byte address 4*index; writes are meant only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module engine_throttle_gimbal_slew #(
    parameter int GIMBAL_AXES = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick in
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  etgs_pkg::t_in_item                  i_in_data,
    // result out
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output etgs_pkg::t_out_item                 o_out_data,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [etgs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // width of the signed gimbal working values
    localparam int GW = 22;

    // ---------------- configuration registers ----------------
    logic [16:0] r_thr_floor;
    logic [16:0] r_thr_ceil;
    logic [26:0] r_spool_up;
    logic [26:0] r_spool_dn;
    logic [7:0]  r_ign_budget;
    logic [14:0] r_gim_limit;
    logic [19:0] r_gim_rate;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_floor  <= '0;
            r_thr_ceil   <= etgs_pkg::THR_FULL;
            r_spool_up   <= '0;
            r_spool_dn   <= '0;
            r_ign_budget <= 8'd1;
            r_gim_limit  <= '0;
            r_gim_rate   <= '0;
        end else if (cfg_wr) begin
            case (etgs_pkg::t_reg_idx'(paddr[4:2]))
                etgs_pkg::REG_THR_FLOOR:  r_thr_floor  <= pwdata[16:0];
                etgs_pkg::REG_THR_CEIL:   r_thr_ceil   <= pwdata[16:0];
                etgs_pkg::REG_SPOOL_UP:   r_spool_up   <= pwdata[26:0];
                etgs_pkg::REG_SPOOL_DN:   r_spool_dn   <= pwdata[26:0];
                etgs_pkg::REG_IGN_BUDGET: r_ign_budget <= pwdata[7:0];
                etgs_pkg::REG_GIM_LIMIT:  r_gim_limit  <= pwdata[14:0];
                etgs_pkg::REG_GIM_RATE:   r_gim_rate   <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (etgs_pkg::t_reg_idx'(paddr[4:2]))
            etgs_pkg::REG_THR_FLOOR:  prdata = 32'(r_thr_floor);
            etgs_pkg::REG_THR_CEIL:   prdata = 32'(r_thr_ceil);
            etgs_pkg::REG_SPOOL_UP:   prdata = 32'(r_spool_up);
            etgs_pkg::REG_SPOOL_DN:   prdata = 32'(r_spool_dn);
            etgs_pkg::REG_IGN_BUDGET: prdata = 32'(r_ign_budget);
            etgs_pkg::REG_GIM_LIMIT:  prdata = 32'(r_gim_limit);
            etgs_pkg::REG_GIM_RATE:   prdata = 32'(r_gim_rate);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- sequencer and working state ----------------
    logic [etgs_pkg::PC_W-1:0] r_pc, n_pc;
    etgs_pkg::t_uword          uw;
    logic                      jump;

    etgs_pkg::t_in_item  r_in, n_in;
    logic                r_run, n_run;
    logic [7:0]          r_ign_cnt, n_ign_cnt;
    logic [16:0]         r_level, n_level;
    logic [16:0]         r_target, n_target;
    logic                r_up, n_up;
    logic [39:0]         r_prod, n_prod;
    logic signed [15:0]  r_ang [GIMBAL_AXES];
    logic signed [15:0]  n_ang [GIMBAL_AXES];
    logic                r_out_valid, n_out_valid;
    etgs_pkg::t_out_item r_out, n_out;

    // divider hookup
    etgs_pkg::t_div_ctl                 div_ctl;
    logic [etgs_pkg::DIV_NUM_W-1:0]     div_num;
    logic [etgs_pkg::DIV_DEN_W-1:0]     div_den;
    logic [etgs_pkg::DIV_NUM_W-1:0]     div_quot;
    logic                               div_busy;

    // datapath helpers
    logic [16:0] req_sat, lo_sat, hi_sat, target_c;
    logic [16:0] thr_diff, thr_step;
    logic [26:0] spool_sel;
    logic [39:0] prod_c;
    logic signed [15:0] ang_first, ang_second;

    assign uw         = etgs_pkg::ucode(r_pc);
    assign o_in_ready = (uw.uop == etgs_pkg::UOP_IDLE);

    etgs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quot     (div_quot),
        .o_busy     (div_busy)
    );

    function automatic logic [16:0] sat_full(input logic [16:0] v);
        return (v > etgs_pkg::THR_FULL) ? etgs_pkg::THR_FULL : v;
    endfunction

    // one axis: bounded step toward the command, then symmetric clamp
    function automatic logic signed [15:0] gim_slew(
        input logic signed [15:0] cur,
        input logic signed [15:0] cmd,
        input logic [20:0]        max_step,
        input logic [14:0]        limit
    );
        logic signed [GW-1:0] d, mx, lim, nv;
        d   = GW'(cmd) - GW'(cur);
        mx  = $signed({1'b0, max_step});
        lim = $signed({7'b0, limit});
        if (d > mx) begin
            d = mx;
        end else if (d < -mx) begin
            d = -mx;
        end
        nv = GW'(cur) + d;
        if (nv < -lim) begin
            nv = -lim;
        end
        if (nv > lim) begin
            nv = lim;
        end
        return nv[15:0];
    endfunction

    // throttle target: request clamped to floor/ceiling when running, else 0
    always_comb begin
        req_sat  = sat_full(r_in.throttle_request);
        lo_sat   = sat_full(r_thr_floor);
        hi_sat   = sat_full(r_thr_ceil);
        target_c = (req_sat < lo_sat) ? lo_sat : req_sat;
        if (target_c > hi_sat) begin
            target_c = hi_sat;
        end
        if (!r_run) begin
            target_c = '0;
        end
    end

    assign prod_c    = r_gim_rate * r_in.elapsed_us;
    assign spool_sel = r_up ? r_spool_up : r_spool_dn;
    assign thr_diff  = r_up ? (r_target - r_level) : (r_level - r_target);
    // step saturates at the remaining distance, so it never overshoots
    assign thr_step  = (div_quot > etgs_pkg::DIV_NUM_W'(thr_diff)) ? thr_diff
                                                                    : div_quot[16:0];

    assign div_num = (uw.uop == etgs_pkg::UOP_DIV_GIM) ? r_prod
                                                      : {4'b0, r_in.elapsed_us, 16'b0};
    assign div_den = (uw.uop == etgs_pkg::UOP_DIV_GIM) ? etgs_pkg::US_PER_S : spool_sel;

    // branch condition of the current microcode word
    always_comb begin
        case (uw.cond)
            etgs_pkg::COND_NEXT:     jump = 1'b0;
            etgs_pkg::COND_ALWAYS:   jump = 1'b1;
            etgs_pkg::COND_NO_INPUT: jump = !i_in_valid;
            etgs_pkg::COND_DIV_BUSY: jump = div_busy;
            etgs_pkg::COND_OUT_FULL: jump = r_out_valid;
            default:                 jump = 1'b0;
        endcase
    end

    always_comb begin
        n_pc        = jump ? uw.target : etgs_pkg::PC_W'(r_pc + 1'b1);
        n_in        = r_in;
        n_run       = r_run;
        n_ign_cnt   = r_ign_cnt;
        n_level     = r_level;
        n_target    = r_target;
        n_up        = r_up;
        n_prod      = r_prod;
        n_ang       = r_ang;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_ctl     = '{load: 1'b0, step: 1'b0};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (uw.uop)
            etgs_pkg::UOP_IDLE: begin
                // tick transfer: run state settles before anything else
                if (i_in_valid) begin
                    n_in = i_in_data;
                    if (i_in_data.run_request && !r_run) begin
                        if (r_ign_cnt < r_ign_budget) begin
                            n_run     = 1'b1;
                            n_ign_cnt = r_ign_cnt + 1'b1;
                        end
                    end else if (!i_in_data.run_request && r_run) begin
                        n_run = 1'b0;
                    end
                end
            end
            etgs_pkg::UOP_PREP: begin
                n_target = target_c;
                n_up     = (target_c > r_level);
                n_prod   = prod_c;
            end
            etgs_pkg::UOP_DIV_THR,
            etgs_pkg::UOP_DIV_GIM: begin
                div_ctl.load = 1'b1;
            end
            etgs_pkg::UOP_DIV_STEP: begin
                div_ctl.step = 1'b1;
            end
            etgs_pkg::UOP_THR: begin
                if (r_target != r_level) begin
                    if (spool_sel == '0) begin
                        n_level = r_target;
                    end else if (r_up) begin
                        n_level = r_level + thr_step;
                    end else begin
                        n_level = r_level - thr_step;
                    end
                end
            end
            etgs_pkg::UOP_GIM: begin
                // axes beyond the two requests are steered toward zero
                for (int i = 0; i < GIMBAL_AXES; i++) begin
                    if (i == 0) begin
                        n_ang[i] = gim_slew(r_ang[i], r_in.gimbal_request_first,
                                            div_quot[20:0], r_gim_limit);
                    end else if (i == 1) begin
                        n_ang[i] = gim_slew(r_ang[i], r_in.gimbal_request_second,
                                            div_quot[20:0], r_gim_limit);
                    end else begin
                        n_ang[i] = gim_slew(r_ang[i], 16'sd0,
                                            div_quot[20:0], r_gim_limit);
                    end
                end
            end
            default: ;
        endcase

        // emit step: load the output register once it is free
        if ((r_pc == etgs_pkg::PC_EMIT) && !r_out_valid) begin
            n_out_valid              = 1'b1;
            n_out.engine_on          = r_run;
            n_out.ignitions_spent    = r_ign_cnt;
            n_out.throttle_delivered = r_level;
            n_out.gimbal_angle_first  = ang_first;
            n_out.gimbal_angle_second = ang_second;
        end
    end

    // reported axes; the second reads zero on a single-axis build
    always_comb begin
        ang_first  = r_ang[0];
        ang_second = '0;
        for (int i = 0; i < GIMBAL_AXES; i++) begin
            if (i == 1) begin
                ang_second = r_ang[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= etgs_pkg::PC_IDLE;
            r_run       <= 1'b0;
            r_ign_cnt   <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < GIMBAL_AXES; i++) begin
                r_ang[i] <= '0;
            end
        end else begin
            r_pc        <= n_pc;
            r_run       <= n_run;
            r_ign_cnt   <= n_ign_cnt;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            r_ang       <= n_ang;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_target <= n_target;
        r_up     <= n_up;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/etgs_chk.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "engine_throttle_gimbal_slew_defines.svh"

module etgs_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input etgs_pkg::t_out_item o_out_data
);

    // a stalled result holds
    `ETGS_ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    // one tick at a time: a transfer closes the input side
    `ETGS_ASSERT_CLK(a_one_tick, i_in_valid && o_in_ready |=> !o_in_ready, "input ready after a transfer")
    // a running engine has used at least one ignition
    `ETGS_ASSERT_OUT(a_ign_count, !o_out_data.engine_on || (o_out_data.ignitions_spent != 8'd0), "running with no ignition spent")
    // delivered throttle stays within full scale
    `ETGS_ASSERT_OUT(a_thr_range, o_out_data.throttle_delivered <= etgs_pkg::THR_FULL, "throttle above full")

endmodule

bind engine_throttle_gimbal_slew etgs_chk u_etgs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- test/engine_throttle_gimbal_slew_checker.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: result checker
// Tracks register writes on the APB port, predicts one result per accepted
// tick and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module engine_throttle_gimbal_slew_checker #(
    parameter int GIMBAL_AXES = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  etgs_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  etgs_pkg::t_out_item             i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [etgs_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                     i_pwdata,
    input  logic                            i_pready,
    output int                              o_mismatches,
    output int                              o_pending
);

    import etgs_pkg::*;

    // register copies
    logic [16:0] thr_floor;
    logic [16:0] thr_ceiling;
    logic [26:0] spool_up_us;
    logic [26:0] spool_dn_us;
    logic [7:0]  ign_budget;
    logic [14:0] gim_limit;
    logic [19:0] gim_rate;

    // engine state copy; four slots, enough for up to four axes
    logic               engine_running;
    logic [7:0]         ignitions;
    logic [16:0]        thr_level;
    logic signed [15:0] angles [0:3];

    t_out_item expected_results[$];
    int        mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [16:0] sat_full(input logic [16:0] v);
        return (v > THR_FULL) ? THR_FULL : v;
    endfunction

    // one tick of the engine: run state, throttle slew, gimbal slew and clamp
    function automatic t_out_item advance_engine(input t_in_item tick);
        t_out_item         r;
        logic [16:0]       req;
        logic [16:0]       lo;
        logic [16:0]       hi;
        logic [16:0]       target;
        logic [26:0]       spool;
        longint unsigned   thr_step;
        longint unsigned   diff;
        longint            max_step;
        longint            lim;
        longint            cmd;
        longint            cur;
        longint            delta;
        int                a;

        req = sat_full(tick.throttle_request);

        if (tick.run_request && !engine_running) begin
            if (ignitions < ign_budget) begin
                engine_running = 1'b1;
                ignitions      = ignitions + 8'd1;
            end
        end else if (!tick.run_request && engine_running) begin
            engine_running = 1'b0;
        end

        if (engine_running) begin
            lo     = sat_full(thr_floor);
            hi     = sat_full(thr_ceiling);
            target = (req < lo) ? lo : req;
            if (target > hi) begin
                target = hi;
            end
        end else begin
            target = '0;
        end

        if (target != thr_level) begin
            spool = (target > thr_level) ? spool_up_us : spool_dn_us;
            if (spool == '0) begin
                thr_level = target;
            end else begin
                diff = (target > thr_level) ? longint'(target - thr_level)
                                            : longint'(thr_level - target);
                thr_step = (longint'(tick.elapsed_us) * 65536) / longint'(spool);
                if (thr_step > diff) begin
                    thr_step = diff;
                end
                if (target > thr_level) begin
                    thr_level = thr_level + 17'(thr_step);
                end else begin
                    thr_level = thr_level - 17'(thr_step);
                end
            end
        end

        max_step = (longint'(gim_rate) * longint'(tick.elapsed_us)) / 1000000;
        lim      = longint'(gim_limit);
        for (a = 0; a < GIMBAL_AXES; a++) begin
            if (a == 0) begin
                cmd = longint'($signed(tick.gimbal_request_first));
            end else if (a == 1) begin
                cmd = longint'($signed(tick.gimbal_request_second));
            end else begin
                cmd = 0;
            end
            cur   = longint'(angles[a]);
            delta = cmd - cur;
            if (delta > max_step) begin
                delta = max_step;
            end
            if (delta < -max_step) begin
                delta = -max_step;
            end
            cur = cur + delta;
            if (cur < -lim) begin
                cur = -lim;
            end
            if (cur > lim) begin
                cur = lim;
            end
            angles[a] = 16'(cur);
        end

        r.engine_on           = engine_running;
        r.ignitions_spent     = ignitions;
        r.throttle_delivered  = thr_level;
        r.gimbal_angle_first  = angles[0];
        r.gimbal_angle_second = (GIMBAL_AXES > 1) ? angles[1] : 16'sd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        logic      bad;

        if (!i_rst_n) begin
            thr_floor      = '0;
            thr_ceiling    = THR_FULL;
            spool_up_us    = '0;
            spool_dn_us    = '0;
            ign_budget     = 8'd1;
            gim_limit      = '0;
            gim_rate       = '0;
            engine_running = 1'b0;
            ignitions      = '0;
            thr_level      = '0;
            for (int a = 0; a < 4; a++) begin
                angles[a] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    REG_THR_FLOOR:  thr_floor   = i_pwdata[16:0];
                    REG_THR_CEIL:   thr_ceiling = i_pwdata[16:0];
                    REG_SPOOL_UP:   spool_up_us = i_pwdata[26:0];
                    REG_SPOOL_DN:   spool_dn_us = i_pwdata[26:0];
                    REG_IGN_BUDGET: ign_budget  = i_pwdata[7:0];
                    REG_GIM_LIMIT:  gim_limit   = i_pwdata[14:0];
                    REG_GIM_RATE:   gim_rate    = i_pwdata[19:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with no tick pending: on=%0d ign=%0d thr=%0d g1=%0d g2=%0d",
                                 $realtime, got.engine_on, got.ignitions_spent,
                                 got.throttle_delivered, got.gimbal_angle_first,
                                 got.gimbal_angle_second);
                    end
                end else begin
                    want = expected_results.pop_front();
                    bad  = (got.engine_on           !== want.engine_on)
                        || (got.ignitions_spent     !== want.ignitions_spent)
                        || (got.throttle_delivered  !== want.throttle_delivered)
                        || (got.gimbal_angle_first  !== want.gimbal_angle_first)
                        || (got.gimbal_angle_second !== want.gimbal_angle_second);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result differs, exp on=%0d ign=%0d thr=%0d g1=%0d g2=%0d",
                                     $realtime, want.engine_on, want.ignitions_spent,
                                     want.throttle_delivered, want.gimbal_angle_first,
                                     want.gimbal_angle_second);
                            $display("%0t:                 got on=%0d ign=%0d thr=%0d g1=%0d g2=%0d",
                                     $realtime, got.engine_on, got.ignitions_spent,
                                     got.throttle_delivered, got.gimbal_angle_first,
                                     got.gimbal_angle_second);
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(advance_engine(i_in_data));
            end
        end

        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ----- test/engine_throttle_gimbal_slew_tb.sv -----
// ----------------------------------------------------------------------------
// Engine throttle / gimbal slew: testbench top
// Drives ticks and register writes into the block, with random gaps on the
// tick side and random stalls on the result side. A directed run covers the
// reset settings, ignition budget, saturation and clamp corners; random
// phases with fresh register settings follow. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module engine_throttle_gimbal_slew_tb;

    import etgs_pkg::*;

    // cycles with no transfer on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT  = 3000;
    // margin for the block's per-tick sequence after the last result
    localparam int TAIL_CYCLES     = 60;
    // short pause so the sequencer is back at idle before register writes
    localparam int IDLE_GUARD      = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int TICKS_PER_PHASE = 80;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending;

    // per-phase idling modes: steady means no gaps on that side
    logic                  in_steady  = 1'b0;
    logic                  out_steady = 1'b0;
    int                    out_hold   = 0;
    int                    idle_cycles = 0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    engine_throttle_gimbal_slew dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    engine_throttle_gimbal_slew_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // gap lengths: mostly a few cycles, now and then long enough to leave the
    // block idle or the output register full for a while
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom_range(0, 3);
        end else if (r < 9) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    // result side: random stalls unless the phase runs steady
    always @(posedge clk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else if (!out_steady && $urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            out_hold  <= pick_gap();
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog: any transfer restarts the count
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // APB write: setup cycle, access cycle, then an idle cycle so the next
    // write's setup never lands in the step that drops psel
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] floor_v, input logic [31:0] ceil_v,
                             input logic [31:0] up_v, input logic [31:0] dn_v,
                             input logic [31:0] budget_v, input logic [31:0] limit_v,
                             input logic [31:0] rate_v);
        write_reg(REG_THR_FLOOR,  floor_v);
        write_reg(REG_THR_CEIL,   ceil_v);
        write_reg(REG_SPOOL_UP,   up_v);
        write_reg(REG_SPOOL_DN,   dn_v);
        write_reg(REG_IGN_BUDGET, budget_v);
        write_reg(REG_GIM_LIMIT,  limit_v);
        write_reg(REG_GIM_RATE,   rate_v);
    endtask

    // Present one tick and return at the edge that takes it. valid stays high
    // on return so a back-to-back tick needs no second assignment that step.
    task automatic push_tick(input t_in_item t);
        int gap;
        gap = in_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send(input logic run, input logic [16:0] thr,
                        input logic signed [15:0] g1, input logic signed [15:0] g2,
                        input logic [19:0] dt);
        t_in_item t;
        t.run_request           = run;
        t.throttle_request      = thr;
        t.gimbal_request_first  = g1;
        t.gimbal_request_second = g2;
        t.elapsed_us            = dt;
        push_tick(t);
    endtask

    // drop valid, wait for every outstanding result, let the sequencer settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_spool();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd100000000;
            3, 4:    return $urandom_range(1000, 200000);
            default: return $urandom_range(200000, 5000000);
        endcase
    endfunction

    // Mostly run requests, so the engine spends most ticks lit and slewing;
    // the odd stop exercises spool-down and re-ignition against the budget.
    // Small time steps keep the slews visible over many ticks.
    function automatic t_in_item random_tick();
        t_in_item t;
        int       pick;
        t.run_request = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            t.throttle_request = 17'($urandom_range(65537, 131071));
        end else if (pick == 1) begin
            t.throttle_request = '0;
        end else if (pick == 2) begin
            t.throttle_request = THR_FULL;
        end else begin
            t.throttle_request = 17'($urandom_range(0, 65536));
        end
        t.gimbal_request_first  = random_angle();
        t.gimbal_request_second = random_angle();
        case ($urandom_range(0, 7))
            0:       t.elapsed_us = '0;
            1:       t.elapsed_us = 20'd1000000;
            2, 3:    t.elapsed_us = 20'($urandom_range(0, 1000000));
            default: t.elapsed_us = 20'($urandom_range(0, 20000));
        endcase
        return t;
    endfunction

    initial begin
        logic [31:0] floor_v;
        logic [31:0] ceil_v;
        logic [31:0] budget_v;
        logic [31:0] limit_v;
        logic [31:0] rate_v;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // ---- reset settings: budget of one, instant spool, zero angle limit
        send(1'b0, 17'd0,      16'sd0,      16'sd0,      20'd0);       // idle tick
        send(1'b1, THR_FULL,   16'sh7FFF,   16'sh8000,   20'd1000000); // ignite, jump
        send(1'b1, 17'h1FFFF,  16'sh8000,   16'sh7FFF,   20'd1000000); // request above full
        send(1'b1, 17'd0,      16'sd5,      -16'sd5,     20'd10);      // jump down to zero
        send(1'b1, 17'd40000,  16'sd0,      16'sd0,      20'd10);      // run while running
        send(1'b0, 17'd40000,  16'sd0,      16'sd0,      20'd10);      // shutdown
        send(1'b0, 17'd40000,  16'sd0,      16'sd0,      20'd10);      // stop while stopped
        send(1'b1, 17'd40000,  16'sd0,      16'sd0,      20'd10);      // budget used up
        drain();

        // ---- narrow throttle window, slow spool, widest gimbal settings
        write_all(32'd10000, 32'd50000, 32'd1000000, 32'd500000,
                  32'd255, 32'd32767, 32'd1048575);
        send(1'b1, 17'd0,      16'sd0,      16'sd0,      20'd100000);  // floor clamps
        send(1'b1, THR_FULL,   16'sh8000,   16'sh7FFF,   20'd1000000); // ceiling, angle clamp
        send(1'b1, 17'd20000,  16'sh8000,   16'sh7FFF,   20'd1000);    // spool down
        send(1'b1, 17'd20000,  16'sd0,      16'sd0,      20'd0);       // zero time step
        send(1'b1, 17'd20000,  16'sd0,      16'sd0,      20'd1);       // unit gimbal step
        send(1'b0, 17'd20000,  16'sd0,      16'sd0,      20'd250000);  // spool to zero
        send(1'b1, 17'h1FFFF,  16'sd300,    -16'sd300,   20'd1000000); // re-ignite
        drain();

        // ---- floor above ceiling, extreme spools, budget below the count
        write_all(32'h1FFFF, 32'd0, 32'd100000000, 32'd1,
                  32'd0, 32'd100, 32'd1);
        send(1'b1, 17'd30000,  16'sh7FFF,   16'sh8000,   20'd1000000); // target is ceiling
        send(1'b0, 17'd30000,  16'sd0,      16'sd0,      20'd0);
        send(1'b1, 17'd30000,  16'sd0,      16'sd0,      20'd1000000); // no ignition left
        send(1'b1, 17'd30000,  16'sh8000,   16'sh7FFF,   20'd999999);  // step floors to 0
        drain();

        // ---- slowest spool both ways
        write_all(32'd0, 32'd65536, 32'd100000000, 32'd100000000,
                  32'd255, 32'd32767, 32'd1000000);
        send(1'b1, THR_FULL,   16'sd1000,   -16'sd1000,  20'd1000000);
        send(1'b0, THR_FULL,   16'sd1000,   -16'sd1000,  20'd1000000);
        drain();

        // ---- random phases, each with a fresh register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       floor_v = 32'd0;
                1:       floor_v = 32'h1FFFF;
                2:       floor_v = 32'd65536;
                default: floor_v = $urandom_range(0, 30000);
            endcase
            case ($urandom_range(0, 7))
                0:       ceil_v = 32'd0;
                1:       ceil_v = 32'h1FFFF;
                2:       ceil_v = 32'd65536;
                default: ceil_v = $urandom_range(30000, 65536);
            endcase
            case ($urandom_range(0, 7))
                0:       budget_v = 32'd0;
                1:       budget_v = 32'd255;
                default: budget_v = $urandom_range(8, 254);
            endcase
            case ($urandom_range(0, 7))
                0:       limit_v = 32'd0;
                1:       limit_v = 32'd32767;
                default: limit_v = $urandom_range(100, 32767);
            endcase
            case ($urandom_range(0, 7))
                0:       rate_v = 32'd0;
                1:       rate_v = 32'd1048575;
                default: rate_v = $urandom_range(1000, 1000000);
            endcase
            write_all(floor_v, ceil_v, random_spool(), random_spool(),
                      budget_v, limit_v, rate_v);

            // some phases run with no gaps on one or both sides
            in_steady  =  ($urandom_range(0, 2) == 0);
            out_steady <= ($urandom_range(0, 2) == 0);

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                push_tick(random_tick());
            end
            drain();
        end

        // everything taken and answered; allow the block's latency once more
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/etgs_pkg.sv
sv/etgs_div.sv
sv/engine_throttle_gimbal_slew.sv
sv/etgs_chk.sv
test/engine_throttle_gimbal_slew_checker.sv
test/engine_throttle_gimbal_slew_tb.sv
